// ===== rtl/firq_pkg.sv =====
// ----------------------------------------------------------------------------
// firq_pkg
// Shared constants for the rounding Q16 FIR filter: field widths, register
// indexes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package firq_pkg;

  // default sizes handed to the top level parameters
  localparam int MAX_TAPS_DEF    = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed field widths
  localparam int COEF_BITS       = 16;
  localparam int ACC_BITS        = 32;
  localparam int OUT_BITS        = 16;
  localparam int TAP_COUNT_BITS  = 5;
  localparam int CFG_DATA_BITS   = 64;
  localparam int CFG_INDEX_BITS  = 3;

  // coefficient register layout
  localparam int COEFS_PER_REG   = 4;
  localparam int NUM_COEF_REGS   = 4;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_COUNT = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEFS_0   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEFS_4   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEFS_8   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEFS_12  = 3'd4;

  // rounding bias added before taking the upper half of the sum
  localparam logic [ACC_BITS-1:0] ROUND_BIAS = 32'h0000_8000;

endpackage

`default_nettype wire

// ===== rtl/firq_in_if.sv =====
// ----------------------------------------------------------------------------
// firq_in_if
// Sample channel: valid/ready handshake carrying one input sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface firq_in_if #(
  parameter int SAMPLE_BITS = firq_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          start_of_row;

  modport source (output valid, output sample_in, output start_of_row, input ready);
  modport sink   (input valid, input sample_in, input start_of_row, output ready);
endinterface

`default_nettype wire

// ===== rtl/firq_out_if.sv =====
// ----------------------------------------------------------------------------
// firq_out_if
// Result channel: valid/ready handshake carrying one filtered sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface firq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [firq_pkg::OUT_BITS-1:0] sample_out;
  logic                                 position_valid;

  modport source (output valid, output sample_out, output position_valid, input ready);
  modport sink   (input valid, input sample_out, input position_valid, output ready);
endinterface

`default_nettype wire

// ===== rtl/fir_filter_q16_round.sv =====
// ----------------------------------------------------------------------------
// fir_filter_q16_round
// Centred FIR filter over signed samples with Q16 rounding.
// ----------------------------------------------------------------------------
// One sample in, one result out, one transaction per clock sustained while
// the sink takes results. The filter is a chain of MAX_TAPS tap cells that
// hold the delay line: each accepted sample shifts one cell along the chain,
// and every cell registers its coefficient times its tap sample at the
// accepting edge. An adder tree sums the registered products into the output
// register whenever that register is free. When the sink stalls, up to two
// results wait (product stage and output register) before the input stops
// taking samples. The sum wraps at 32 bits; sample_out is the sum plus
// 0x8000, upper 16 bits. start_of_row clears the delay line, so earlier
// samples count as zero; position_valid marks results of real row positions.
// Configuration writes take effect from the next cycle. The user must make
// them only while no transaction is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_q16_round #(
  parameter int MAX_TAPS    = firq_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = firq_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  firq_in_if.sink                                  in_ch,
  firq_out_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [firq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [firq_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int KW = $clog2(MAX_TAPS + 1);
  localparam int AB = firq_pkg::ACC_BITS;
  localparam int TN = 1 << $clog2(MAX_TAPS);

  logic signed [firq_pkg::COEF_BITS-1:0] tap_coef [MAX_TAPS];
  logic [KW-1:0]                         lag;
  logic signed [SAMPLE_BITS-1:0]         line [MAX_TAPS+1];
  logic [AB-1:0]                         prod [MAX_TAPS];
  logic [AB-1:0]                         tree [2*TN-1];
  logic                                  accept;
  logic                                  out_free;
  logic                                  prod_adv;
  logic                                  prod_valid_r, prod_valid_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic                                  pos_prod_r;
  logic                                  pos_out_r;
  logic                                  pos_valid_nxt;
  logic [KW-1:0]                         seen_r, seen_nxt, seen_cur;
  logic [AB-1:0]                         sum_r, sum_nxt;
  logic [AB-1:0]                         sum_rnd;

  // configuration
  firq_coef_bank #(
    .MAX_TAPS (MAX_TAPS)
  ) u_coef_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tap_coef  (tap_coef),
    .lag       (lag)
  );

  // take a sample when the product stage is empty or moving on
  assign out_free    = !out_valid_r || out_ch.ready;
  assign prod_adv    = !prod_valid_r || out_free;
  assign in_ch.ready = prod_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  // tap chain: cell 0 sees the new sample, cell i the sample held by cell i-1
  assign line[0] = in_ch.sample_in;

  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_tap
    firq_tap_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .advance    (accept),
      .row_start  ((i == 0) ? 1'b0 : in_ch.start_of_row),
      .sample_in  (line[i]),
      .coef       (tap_coef[i]),
      .sample_out (line[i+1]),
      .prod_out   (prod[i])
    );
  end

  // adder tree over the registered products, padded to a power of two
  for (genvar j = 0; j < TN; j++) begin : g_leaf
    if (j < MAX_TAPS) begin : g_used
      assign tree[TN-1+j] = prod[j];
    end else begin : g_pad
      assign tree[TN-1+j] = '0;
    end
  end

  for (genvar n = 0; n < TN - 1; n++) begin : g_node
    assign tree[n] = tree[2*n+1] + tree[2*n+2];
  end

  assign sum_nxt = tree[0];

  // row position tracking, saturating at the chain length
  always_comb begin
    seen_cur      = in_ch.start_of_row ? '0 : seen_r;
    seen_nxt      = (seen_cur == KW'(MAX_TAPS)) ? seen_cur : seen_cur + KW'(1);
    pos_valid_nxt = (seen_cur >= lag);
  end

  // stage valids: fill on accept, move on when the next stage is free
  always_comb begin
    prod_valid_nxt = prod_adv ? accept : prod_valid_r;
    out_valid_nxt  = out_free ? prod_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      seen_r       <= '0;
      pos_prod_r   <= 1'b0;
      pos_out_r    <= 1'b0;
      sum_r        <= '0;
    end else begin
      prod_valid_r <= prod_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (accept) begin
        seen_r     <= seen_nxt;
        pos_prod_r <= pos_valid_nxt;
      end
      // position flag travels with its products into the output register
      if (out_free) begin
        sum_r     <= sum_nxt;
        pos_out_r <= pos_prod_r;
      end
    end
  end

  // round and take the upper half
  assign sum_rnd               = sum_r + firq_pkg::ROUND_BIAS;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.sample_out     = sum_rnd[AB-1 -: firq_pkg::OUT_BITS];
  assign out_ch.position_valid = pos_out_r;

endmodule

`default_nettype wire

// ===== rtl/firq_coef_bank.sv =====
// ----------------------------------------------------------------------------
// firq_coef_bank
// Configuration registers. Keeps the tap count and raw coefficients, and
// holds a copy of the coefficients already reversed over the active taps
// (zero beyond them) plus the output lag, so the tap cells see a fixed
// coefficient each.
// ----------------------------------------------------------------------------
`default_nettype none

module firq_coef_bank #(
  parameter int MAX_TAPS = firq_pkg::MAX_TAPS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [firq_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [firq_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output logic signed [firq_pkg::COEF_BITS-1:0]       tap_coef [MAX_TAPS],
  output logic [$clog2(MAX_TAPS+1)-1:0]               lag
);

  localparam int KW = $clog2(MAX_TAPS + 1);
  localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = (KW > firq_pkg::TAP_COUNT_BITS) ? KW : firq_pkg::TAP_COUNT_BITS;
  localparam int CB = firq_pkg::COEF_BITS;

  logic [firq_pkg::TAP_COUNT_BITS-1:0] tap_count_r, tap_count_nxt;
  logic signed [CB-1:0]                coef_r [MAX_TAPS];
  logic signed [CB-1:0]                coef_nxt [MAX_TAPS];
  logic signed [CB-1:0]                tap_coef_r [MAX_TAPS];
  logic signed [CB-1:0]                tap_coef_nxt [MAX_TAPS];
  logic [KW-1:0]                       lag_r, lag_nxt;
  logic [CW-1:0]                       tc_wide;
  logic [KW-1:0]                       k_nxt;

  // apply register writes
  always_comb begin
    tap_count_nxt = tap_count_r;
    coef_nxt      = coef_r;
    if (cfg_we) begin
      if (cfg_index == firq_pkg::REG_TAP_COUNT) begin
        tap_count_nxt = cfg_data[firq_pkg::TAP_COUNT_BITS-1:0];
      end
      for (int r = 0; r < firq_pkg::NUM_COEF_REGS; r++) begin
        for (int j = 0; j < firq_pkg::COEFS_PER_REG; j++) begin
          if ((r * firq_pkg::COEFS_PER_REG + j) < MAX_TAPS &&
              cfg_index == firq_pkg::CFG_INDEX_BITS'(int'(firq_pkg::REG_COEFS_0) + r)) begin
            coef_nxt[r * firq_pkg::COEFS_PER_REG + j] = cfg_data[CB*j +: CB];
          end
        end
      end
    end
  end

  // effective tap count: zero acts as one, large values clamp
  always_comb begin
    tc_wide = CW'(tap_count_nxt);
    if (tc_wide == '0) begin
      k_nxt = KW'(1);
    end else if (tc_wide > CW'(MAX_TAPS)) begin
      k_nxt = KW'(MAX_TAPS);
    end else begin
      k_nxt = tc_wide[KW-1:0];
    end
    lag_nxt = (k_nxt - KW'(1)) - (k_nxt >> 1);
  end

  // reverse coefficients over the active taps
  always_comb begin
    logic [KW-1:0] idx;
    idx = '0;
    for (int j = 0; j < MAX_TAPS; j++) begin
      idx = k_nxt - KW'(1) - KW'(j);
      if (KW'(j) < k_nxt) begin
        tap_coef_nxt[j] = coef_nxt[idx[IW-1:0]];
      end else begin
        tap_coef_nxt[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= firq_pkg::TAP_COUNT_BITS'(1);
      lag_r       <= '0;
      for (int j = 0; j < MAX_TAPS; j++) begin
        coef_r[j]     <= '0;
        tap_coef_r[j] <= '0;
      end
    end else begin
      tap_count_r <= tap_count_nxt;
      lag_r       <= lag_nxt;
      coef_r      <= coef_nxt;
      tap_coef_r  <= tap_coef_nxt;
    end
  end

  assign tap_coef = tap_coef_r;
  assign lag      = lag_r;

endmodule

`default_nettype wire

// ===== rtl/firq_tap_cell.sv =====
// ----------------------------------------------------------------------------
// firq_tap_cell
// One cell of the tap chain: holds one delay-line sample, hands it to its
// downstream neighbour and registers the product of its tap sample and
// coefficient.
// ----------------------------------------------------------------------------
`default_nettype none

module firq_tap_cell #(
  parameter int SAMPLE_BITS = firq_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  advance,
  input  wire logic                                  row_start,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample_in,
  input  wire logic signed [firq_pkg::COEF_BITS-1:0] coef,
  output logic signed [SAMPLE_BITS-1:0]              sample_out,
  output logic [firq_pkg::ACC_BITS-1:0]              prod_out
);

  localparam int PW = SAMPLE_BITS + firq_pkg::COEF_BITS;
  localparam int AB = firq_pkg::ACC_BITS;

  logic signed [SAMPLE_BITS-1:0] tap;
  logic signed [PW-1:0]          prod;
  logic signed [PW+AB-1:0]       prod_wide;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [AB-1:0]                 prod_r, prod_nxt;

  // row start drops the past sample; product wraps into the sum width
  always_comb begin
    tap       = row_start ? '0 : sample_in;
    prod      = tap * coef;
    prod_wide = (PW+AB)'(prod);
    prod_nxt  = prod_wide[AB-1:0];
  end

  // advance on each accepted transaction, hold otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      prod_r   <= '0;
    end else if (advance) begin
      sample_r <= tap;
      prod_r   <= prod_nxt;
    end
  end

  assign sample_out = sample_r;
  assign prod_out   = prod_r;

endmodule

`default_nettype wire
